// ===== rtl/mfr_pkg.sv =====
package mfr_pkg;

  // Frame header bytes
  localparam logic [7:0] HDR_FIRST  = 8'hFC;
  localparam logic [7:0] HDR_SECOND = 8'hEE;

  // CRC-32 settings: MSB-first, no reflection, no final xor
  localparam logic [31:0] CRC_POLY = 32'h04C11DB7;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

  // Byte steps left after the first one when a word is loaded into the CRC unit
  localparam logic [1:0] CRC_TAIL_STEPS = 2'd3;

  // Result status codes
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_CRC_ERR = 1'b1;

  // Control from the frame sequencer to the CRC unit
  typedef struct packed {
    logic        init;
    logic        load;
    logic [31:0] word;
  } crc_ctl_t;

  // Advance the CRC register by eight bit steps
  function automatic logic [31:0] crc_shift8(input logic [31:0] v);
    logic [31:0] c;
    c = v;
    for (int i = 0; i < 8; i++) begin
      c = c[31] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

// ===== rtl/mfr_rx_if.sv =====
interface mfr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/mfr_fb_if.sv =====
interface mfr_fb_if;
  logic               valid;
  logic               ready;
  logic               frame_status;
  logic        [3:0]  drive_id;
  logic        [2:0]  motor_mode;
  logic               timeout_flag;
  logic signed [7:0]  stator_temp;
  logic        [7:0]  winding_temp;
  logic        [7:0]  voltage_half_volts;
  logic        [31:0] error_bits;
  logic        [2:0]  warn_code;
  logic signed [15:0] torque_val;
  logic signed [15:0] speed_val;
  logic signed [31:0] angle_val;

  modport source (
    output valid, output frame_status, output drive_id, output motor_mode,
    output timeout_flag, output stator_temp, output winding_temp,
    output voltage_half_volts, output error_bits, output warn_code,
    output torque_val, output speed_val, output angle_val,
    input ready
  );
  modport sink (
    input valid, input frame_status, input drive_id, input motor_mode,
    input timeout_flag, input stator_temp, input winding_temp,
    input voltage_half_volts, input error_bits, input warn_code,
    input torque_val, input speed_val, input angle_val,
    output ready
  );
endinterface

// ===== rtl/mfr_crc.sv =====
module mfr_crc
  import mfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  crc_ctl_t    ctl,
  output logic [31:0] crc,
  output logic        busy
);

  logic [1:0] steps_left;

  assign busy = (steps_left != 2'd0);

  // Count the byte steps still owed for the current word
  always_ff @(posedge clk) begin
    if (rst) begin
      steps_left <= 2'd0;
    end else if (ctl.load) begin
      steps_left <= CRC_TAIL_STEPS;
    end else if (busy) begin
      steps_left <= steps_left - 2'd1;
    end
  end

  // Seed at frame start, fold in a word, then shift one byte per cycle
  always_ff @(posedge clk) begin
    if (ctl.init) begin
      crc <= CRC_INIT;
    end else if (ctl.load) begin
      crc <= crc_shift8(crc ^ ctl.word);
    end else if (busy) begin
      crc <= crc_shift8(crc);
    end
  end

endmodule

// ===== rtl/motor_feedback_frame_receiver.sv =====
// Motor feedback frame receiver.
// rx (valid/ready) takes one received serial byte per request. The block
// hunts for the header 0xFC 0xEE, collects a 26-byte frame and, on the last
// byte, checks the CRC-32 over bytes 2..21 against the little-endian word in
// bytes 22..25. fb (valid/ready) then carries one request with the status
// and the decoded raw fields; on a checksum mismatch only drive_id is kept.
// Throughput: one byte per cycle, but for the last byte held off below.
// The result is registered and presented the cycle after the last frame
// byte is accepted. The CRC unit folds in each 32-bit word one byte step
// per cycle, which the next word (at least four bytes later) never outruns.
// Stalls: bytes keep flowing while a result waits on fb; only the last byte
// of a frame is held off while the previous result is still not taken.
// Reset (rst, synchronous) returns the block to header hunting and drops
// any pending result; frame storage is not cleared.
module motor_feedback_frame_receiver
  import mfr_pkg::*;
(
  input logic      clk,
  input logic      rst,
  mfr_rx_if.sink   rx,
  mfr_fb_if.source fb
);

  // Byte position codes
  localparam logic [4:0] POS_HUNT       = 5'd0;
  localparam logic [4:0] POS_HDR        = 5'd1;
  localparam logic [4:0] POS_FIRST_DATA = 5'd2;
  localparam logic [4:0] POS_FIELD_LAST = 5'd19;
  localparam logic [4:0] POS_LAST       = 5'd25;

  logic [4:0]  pos;
  logic [4:0]  pos_next;
  logic [7:0]  frame [POS_FIRST_DATA:POS_FIELD_LAST];
  logic [23:0] word_acc;
  logic        accept;
  logic        data_byte;
  logic        emit;
  logic        crc_ok;
  logic [31:0] crc;
  logic        crc_busy;
  crc_ctl_t    crc_ctl;

  // Hold off only the last byte while the previous result is not taken
  assign rx.ready  = !((pos == POS_LAST) && fb.valid && !fb.ready);
  assign accept    = rx.valid && rx.ready;
  assign data_byte = accept && (pos >= POS_FIRST_DATA) && (pos <= POS_LAST);
  assign emit      = accept && (pos == POS_LAST);

  // Sequence the byte position
  always_comb begin
    pos_next = pos;
    if (accept) begin
      if (pos == POS_HUNT) begin
        pos_next = (rx.rx_byte == HDR_FIRST) ? POS_HDR : POS_HUNT;
      end else if (pos == POS_HDR) begin
        if (rx.rx_byte == HDR_SECOND) begin
          pos_next = POS_FIRST_DATA;
        end else begin
          pos_next = (rx.rx_byte == HDR_FIRST) ? POS_HDR : POS_HUNT;
        end
      end else if (pos >= POS_LAST) begin
        pos_next = POS_HUNT;
      end else begin
        pos_next = pos + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= POS_HUNT;
    end else begin
      pos <= pos_next;
    end
  end

  // Keep the bytes that feed result fields
  always_ff @(posedge clk) begin
    if (data_byte && (pos <= POS_FIELD_LAST)) begin
      frame[pos] <= rx.rx_byte;
    end
  end

  // Keep the last three data bytes to build each little-endian word
  always_ff @(posedge clk) begin
    if (data_byte) begin
      word_acc <= {rx.rx_byte, word_acc[23:8]};
    end
  end

  // Seed on the second header byte, load on the fourth byte of each CRC word
  always_comb begin
    crc_ctl.init = accept && (pos == POS_HDR) && (rx.rx_byte == HDR_SECOND);
    crc_ctl.load = data_byte && (pos[1:0] == 2'b01) && (pos != POS_LAST);
    crc_ctl.word = {rx.rx_byte, word_acc};
  end

  mfr_crc u_crc (
    .clk  (clk),
    .rst  (rst),
    .ctl  (crc_ctl),
    .crc  (crc),
    .busy (crc_busy)
  );

  assign crc_ok = (crc == {rx.rx_byte, word_acc});

  // Result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      fb.valid <= 1'b0;
    end else if (emit) begin
      fb.valid <= 1'b1;
    end else if (fb.ready) begin
      fb.valid <= 1'b0;
    end
  end

  // Capture the decoded fields; zero all but the drive id on a mismatch
  always_ff @(posedge clk) begin
    if (emit) begin
      fb.drive_id <= frame[2][3:0];
      if (crc_ok) begin
        fb.frame_status       <= STATUS_OK;
        fb.motor_mode         <= frame[2][6:4];
        fb.timeout_flag       <= frame[2][7];
        fb.stator_temp        <= frame[3];
        fb.winding_temp       <= frame[4];
        fb.voltage_half_volts <= frame[5];
        fb.torque_val         <= {frame[7], frame[6]};
        fb.speed_val          <= {frame[9], frame[8]};
        fb.angle_val          <= {frame[13], frame[12], frame[11], frame[10]};
        fb.error_bits         <= {frame[17], frame[16], frame[15], frame[14]};
        fb.warn_code          <= frame[19][7:5];
      end else begin
        fb.frame_status       <= STATUS_CRC_ERR;
        fb.motor_mode         <= 3'd0;
        fb.timeout_flag       <= 1'b0;
        fb.stator_temp        <= 8'sd0;
        fb.winding_temp       <= 8'd0;
        fb.voltage_half_volts <= 8'd0;
        fb.torque_val         <= 16'sd0;
        fb.speed_val          <= 16'sd0;
        fb.angle_val          <= 32'sd0;
        fb.error_bits         <= 32'd0;
        fb.warn_code          <= 3'd0;
      end
    end
  end

`ifndef SYNTH
  // A new result appears only after the last frame byte was taken
  a_rise_after_last: assert property (@(posedge clk) disable iff (rst)
    $rose(fb.valid) |-> $past(rx.valid && rx.ready && (pos == POS_LAST)))
    else $error("result raised without a completed frame");

  // The CRC unit has finished the last word before the check byte arrives
  a_crc_done: assert property (@(posedge clk) disable iff (rst)
    emit |-> !crc_busy)
    else $error("CRC still running at frame end");

  // A pending result is never overwritten by a new frame
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (fb.valid && !fb.ready) |=> $stable(fb.drive_id) && $stable(fb.frame_status))
    else $error("pending result overwritten");

  // Mismatched frames carry zeroed payload
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (fb.valid && (fb.frame_status == STATUS_CRC_ERR)) |->
      (fb.angle_val == 32'sd0) && (fb.error_bits == 32'd0) &&
      (fb.torque_val == 16'sd0))
    else $error("mismatch result carries payload");
`endif

endmodule

// ===== tb/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mfr_pkg::*;

  localparam int FRAME_BYTES = 26;
  localparam int BODY_BYTES  = 20;
  localparam int RANDOM_BYTES = 1650;

  typedef enum logic {CRC_GOOD, CRC_BAD} crc_sel_e;
  typedef enum logic [1:0] {SINK_OPEN, SINK_COIN, SINK_EVERY4, SINK_SPARSE} sink_mode_e;

  typedef struct packed {
    logic        frame_status;
    logic [3:0]  drive_id;
    logic [2:0]  motor_mode;
    logic        timeout_flag;
    logic [7:0]  stator_temp;
    logic [7:0]  winding_temp;
    logic [7:0]  voltage_half_volts;
    logic [31:0] error_bits;
    logic [2:0]  warn_code;
    logic [15:0] torque_val;
    logic [15:0] speed_val;
    logic [31:0] angle_val;
  } fb_result_t;

  // One directed frame: lead-in bytes (low byte first), then header, body
  // (frame bytes 2..21, byte 2 in the low bits) and checksum word
  typedef struct packed {
    logic [2:0]   lead_len;
    logic [31:0]  lead;
    logic [159:0] body;
    crc_sel_e     crc_sel;
    logic         typed;
    fb_result_t   want;
  } frame_row_t;

  logic clk;
  logic rst;

  mfr_rx_if rx_ch ();
  mfr_fb_if fb_ch ();

  motor_feedback_frame_receiver i_dut (
    .clk(clk),
    .rst(rst),
    .rx (rx_ch),
    .fb (fb_ch)
  );

  // Receiver shadow state
  logic [4:0] frame_pos;
  logic [7:0] frame_buf [FRAME_BYTES];

  fb_result_t feedback_due [$];
  int         error_count = 0;
  int         burst_left;
  int         frame_bytes;

  sink_mode_e sink_mode = SINK_OPEN;
  int         sink_left = 0;
  int         sink_tick = 0;

  frame_row_t dir_rows [9] = '{
    // all-zero body
    '{3'd0, 32'h0, {20{8'h00}}, CRC_GOOD, 1'b1, '0},
    // all-ones body
    '{3'd0, 32'h0, {20{8'hFF}}, CRC_GOOD, 1'b1,
      '{STATUS_OK, 4'hF, 3'h7, 1'b1, 8'hFF, 8'hFF, 8'hFF, 32'hFFFFFFFF, 3'h7,
        16'hFFFF, 16'hFFFF, 32'hFFFFFFFF}},
    // checksum mismatch keeps only the drive id
    '{3'd0, 32'h0, {20{8'hFF}}, CRC_BAD, 1'b1,
      '{STATUS_CRC_ERR, 4'hF, 3'h0, 1'b0, 8'h0, 8'h0, 8'h0, 32'h0, 3'h0,
        16'h0, 16'h0, 32'h0}},
    // stray second header byte while hunting, signed extremes in the body
    '{3'd1, 32'h000000EE, 160'hA55AA000_80000001_80000000_7FFF8000_FF00801C,
      CRC_GOOD, 1'b0, '0},
    // bad second header byte drops back to hunting
    '{3'd2, 32'h000012FC, 160'h13121110_0F0E0D0C_0B0A0908_07060504_03020115,
      CRC_GOOD, 1'b0, '0},
    // repeated first header byte stays one byte in, calibrate mode
    '{3'd1, 32'h000000FC, 160'h3C2D1E0F_F0E1D2C3_B4A59687_78695A4B_3C2D7F27,
      CRC_GOOD, 1'b0, '0},
    // run of first header bytes
    '{3'd3, 32'h00FCFCFC, 160'hDEADBEEF_CAFEF00D_12345678_9ABCDEF0_0F1E2D3E,
      CRC_GOOD, 1'b0, '0},
    // checksum mismatch, calibrate mode byte
    '{3'd0, 32'h0, 160'h11223344_55667788_99AABBCC_DDEEFF00_1122332A, CRC_BAD, 1'b1,
      '{STATUS_CRC_ERR, 4'hA, 3'h0, 1'b0, 8'h0, 8'h0, 8'h0, 32'h0, 3'h0,
        16'h0, 16'h0, 32'h0}},
    // hunt through mixed junk, lock mode with timeout flag
    '{3'd4, 32'hFC55FC00, 160'h00000000_00000000_00000000_00000000_00000080,
      CRC_GOOD, 1'b0, '0}
  };

  // CRC over the body as five little-endian words, MSB first
  function automatic logic [31:0] body_crc(input logic [159:0] body);
    logic [31:0] c;
    c = CRC_INIT;
    for (int w = 0; w < BODY_BYTES / 4; w++) begin
      c ^= body[32*w +: 32];
      for (int i = 0; i < 32; i++) begin
        c = c[31] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
    end
    return c;
  endfunction

  // Advance the shadow receiver by one byte; returns 1 with the decoded frame
  function automatic bit track_byte(input logic [7:0] b, output fb_result_t r);
    logic [159:0] body;
    logic [31:0]  sent_crc;
    logic [7:0]   mb;
    r = '0;
    if (frame_pos == 0) begin
      if (b == HDR_FIRST) begin
        frame_buf[0] = b;
        frame_pos = 5'd1;
      end
      return 1'b0;
    end
    if (frame_pos == 1) begin
      if (b == HDR_SECOND) begin
        frame_buf[1] = b;
        frame_pos = 5'd2;
      end else begin
        frame_buf[0] = b;
        frame_pos = (b == HDR_FIRST) ? 5'd1 : 5'd0;
      end
      return 1'b0;
    end
    if (frame_pos >= FRAME_BYTES) begin
      frame_pos = 5'd0;
      return 1'b0;
    end
    frame_buf[frame_pos] = b;
    if (frame_pos != FRAME_BYTES - 1) begin
      frame_pos++;
      return 1'b0;
    end

    // Last byte: check the checksum and decode
    frame_pos = 5'd0;
    for (int k = 0; k < BODY_BYTES; k++) body[8*k +: 8] = frame_buf[2+k];
    sent_crc = {frame_buf[25], frame_buf[24], frame_buf[23], frame_buf[22]};
    mb = frame_buf[2];
    r.drive_id = mb[3:0];
    if (body_crc(body) != sent_crc) begin
      r.frame_status = STATUS_CRC_ERR;
      return 1'b1;
    end
    r.frame_status       = STATUS_OK;
    r.motor_mode         = mb[6:4];
    r.timeout_flag       = mb[7];
    r.stator_temp        = frame_buf[3];
    r.winding_temp       = frame_buf[4];
    r.voltage_half_volts = frame_buf[5];
    r.error_bits         = {frame_buf[17], frame_buf[16], frame_buf[15], frame_buf[14]};
    r.warn_code          = frame_buf[19][7:5];
    r.torque_val         = {frame_buf[7], frame_buf[6]};
    r.speed_val          = {frame_buf[9], frame_buf[8]};
    r.angle_val          = {frame_buf[13], frame_buf[12], frame_buf[11], frame_buf[10]};
    return 1'b1;
  endfunction

  // Send one byte request, idling between bursts
  task automatic push_byte(input logic [7:0] b, input bit typed, input fb_result_t want);
    fb_result_t r;
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 5);
      rx_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 12);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    @(posedge clk);
    while (!rx_ch.ready) @(posedge clk);
    burst_left--;
    frame_bytes++;
    if (track_byte(b, r)) feedback_due.push_back(typed ? want : r);
  endtask

  task automatic send_frame(input logic [2:0] lead_len, input logic [31:0] lead,
                            input logic [159:0] body, input crc_sel_e sel,
                            input bit typed, input fb_result_t want);
    logic [31:0] crc;
    crc = body_crc(body);
    if (sel == CRC_BAD) crc ^= 32'h1 << $urandom_range(0, 31);
    for (int i = 0; i < lead_len; i++) push_byte(lead[8*i +: 8], 1'b0, '0);
    push_byte(HDR_FIRST, 1'b0, '0);
    push_byte(HDR_SECOND, 1'b0, '0);
    for (int k = 0; k < BODY_BYTES; k++) push_byte(body[8*k +: 8], 1'b0, '0);
    for (int k = 0; k < 3; k++) push_byte(crc[8*k +: 8], 1'b0, '0);
    push_byte(crc[31:24], typed, want);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      error_count++;
    end
  endtask

  task automatic compare_feedback(input fb_result_t want, input fb_result_t got);
    check_field("frame_status", 32'(want.frame_status), 32'(got.frame_status));
    check_field("drive_id", 32'(want.drive_id), 32'(got.drive_id));
    check_field("motor_mode", 32'(want.motor_mode), 32'(got.motor_mode));
    check_field("timeout_flag", 32'(want.timeout_flag), 32'(got.timeout_flag));
    check_field("stator_temp", 32'(want.stator_temp), 32'(got.stator_temp));
    check_field("winding_temp", 32'(want.winding_temp), 32'(got.winding_temp));
    check_field("voltage_half_volts", 32'(want.voltage_half_volts),
                32'(got.voltage_half_volts));
    check_field("error_bits", want.error_bits, got.error_bits);
    check_field("warn_code", 32'(want.warn_code), 32'(got.warn_code));
    check_field("torque_val", 32'(want.torque_val), 32'(got.torque_val));
    check_field("speed_val", 32'(want.speed_val), 32'(got.speed_val));
    check_field("angle_val", want.angle_val, got.angle_val);
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Take feedback requests and stall on a changing pattern
  always @(posedge clk) begin : fb_drain
    fb_result_t got;
    logic       nxt;
    if (rst) begin
      fb_ch.ready <= 1'b0;
    end else begin
      if (fb_ch.valid && fb_ch.ready) begin
        got.frame_status       = fb_ch.frame_status;
        got.drive_id           = fb_ch.drive_id;
        got.motor_mode         = fb_ch.motor_mode;
        got.timeout_flag       = fb_ch.timeout_flag;
        got.stator_temp        = fb_ch.stator_temp;
        got.winding_temp       = fb_ch.winding_temp;
        got.voltage_half_volts = fb_ch.voltage_half_volts;
        got.error_bits         = fb_ch.error_bits;
        got.warn_code          = fb_ch.warn_code;
        got.torque_val         = fb_ch.torque_val;
        got.speed_val          = fb_ch.speed_val;
        got.angle_val          = fb_ch.angle_val;
        if (feedback_due.size() == 0) begin
          $error("feedback request with none pending: status %0h id %0h",
                 got.frame_status, got.drive_id);
          error_count++;
        end else begin
          compare_feedback(feedback_due.pop_front(), got);
        end
      end

      // Switch stall pattern now and then
      if (sink_left == 0) begin
        sink_mode = sink_mode_e'($urandom_range(0, 3));
        sink_left = $urandom_range(20, 300);
      end else begin
        sink_left--;
      end
      sink_tick++;
      case (sink_mode)
        SINK_OPEN:   nxt = 1'b1;
        SINK_COIN:   nxt = 1'($urandom_range(0, 1));
        SINK_EVERY4: nxt = (sink_tick % 4 == 0);
        default:     nxt = ($urandom_range(0, 7) == 0);
      endcase
      fb_ch.ready <= nxt;
    end
  end

  // Stimulus
  initial begin
    int pick;
    int n;
    rst           = 1'b1;
    rx_ch.valid   = 1'b0;
    rx_ch.rx_byte = 8'h00;
    frame_pos     = 5'd0;
    burst_left    = 0;
    frame_bytes   = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed frames
    foreach (dir_rows[i]) begin
      send_frame(dir_rows[i].lead_len, dir_rows[i].lead, dir_rows[i].body,
                 dir_rows[i].crc_sel, dir_rows[i].typed, dir_rows[i].want);
    end

    // Random traffic: mostly clean frames, some junk and broken frames
    while (frame_bytes < RANDOM_BYTES) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        send_frame(3'($urandom_range(0, 2)), $urandom,
                   {$urandom, $urandom, $urandom, $urandom, $urandom},
                   ($urandom_range(0, 99) < 15) ? CRC_BAD : CRC_GOOD, 1'b0, '0);
      end else if (pick < 80) begin
        n = $urandom_range(1, 6);
        repeat (n) push_byte(8'($urandom_range(0, 255)), 1'b0, '0);
      end else if (pick < 90) begin
        // header start with a wrong (often repeated) second byte
        push_byte(HDR_FIRST, 1'b0, '0);
        push_byte(($urandom_range(0, 2) == 0) ? HDR_FIRST : 8'($urandom_range(0, 255)),
                  1'b0, '0);
      end else begin
        // truncated frame: the next bytes get swallowed as its body
        n = $urandom_range(0, 23);
        push_byte(HDR_FIRST, 1'b0, '0);
        push_byte(HDR_SECOND, 1'b0, '0);
        repeat (n) push_byte(8'($urandom_range(0, 255)), 1'b0, '0);
      end
    end
    rx_ch.valid <= 1'b0;

    // Drain and let the block settle
    while (feedback_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
